/* rtl/core/rmq_pkg.sv */
`timescale 1ns / 1ps

package rmq_pkg;

   localparam int MAX_ELEMENTS = 4096;
   localparam int BLOCK_SIZE   = 64;
   localparam int VALUE_WIDTH  = 32;
   localparam int NUM_BLOCKS   = MAX_ELEMENTS / BLOCK_SIZE;
   localparam int NUM_LEVELS   = 7;
   localparam int ADDR_W       = 12;
   localparam int COUNT_W      = 13;
   localparam int POS_W        = 6;
   localparam int BLK_W        = 6;
   localparam int LVL_W        = 3;
   localparam int DEPTH_W      = 7;
   localparam int BMT_DEPTH    = NUM_BLOCKS * NUM_LEVELS;
   localparam int REQ_DATA_W   = 64;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_QUERY  = 2'd2,
      CMD_UNUSED = 2'd3
   } command_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH,
      S_A_START, S_A_BMIN, S_A_POP, S_A_POP_EL, S_A_POP_CMP, S_A_WRITE,
      S_A_LVL, S_A_LVL1, S_A_LVL2,
      S_Q_CHECK, S_Q_IB_M, S_Q_IB_E, S_Q_MID0, S_Q_MID1, S_Q_MID2,
      S_Q_RIGHT, S_Q_OUT
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_CLEAR,
      OP_A_START, OP_A_BMIN, OP_POP_RD, OP_POP_EL, OP_POP_CMP, OP_A_WRITE,
      OP_LVL_RD0, OP_LVL_RD1, OP_LVL_WR,
      OP_Q_ERR, OP_Q_EMPTY, OP_Q_LEFT, OP_IB_MASK, OP_IB_ELEM,
      OP_MID0, OP_MID1, OP_MID2, OP_Q_RIGHT, OP_Q_OUT
   } dp_op_type;

   typedef struct packed {
      command_type cmd;
      logic        full;
      logic        depth_zero;
      logic        pop_hit;
      logic        pos_last;
      logic        lvl_done;
      logic        q_err;
      logic        q_empty;
      logic        same_block;
      logic        has_mid;
      logic        has_right;
      logic        right_phase;
      logic        rsp_free;
   } status_type;

   // Index of the lowest set bit; 63 for an all-zero word.
   function automatic logic [POS_W-1:0] lowest_bit(input logic [BLOCK_SIZE-1:0] m);
      logic [POS_W-1:0] idx;
      idx = POS_W'(BLOCK_SIZE - 1);
      for (int i = BLOCK_SIZE - 1; i >= 0; i--) begin
         if (m[i]) begin
            idx = POS_W'(i);
         end
      end
      return idx;
   endfunction

   function automatic logic [LVL_W-1:0] floor_log2(input logic [DEPTH_W-1:0] x);
      logic [LVL_W-1:0] k;
      k = '0;
      for (int i = 0; i < DEPTH_W; i++) begin
         if (x[i]) begin
            k = LVL_W'(i);
         end
      end
      return k;
   endfunction

endpackage

/* rtl/core/rmq_ram.sv */
`timescale 1ns / 1ps

module rmq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/rmq_ctrl.sv */
`timescale 1ns / 1ps

module rmq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  rmq_pkg::status_type   status,
   output rmq_pkg::dp_op_type    op
);

   rmq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rmq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rmq_pkg::S_IDLE: begin
            if (req_tvalid) state_in = rmq_pkg::S_DISPATCH;
         end
         rmq_pkg::S_DISPATCH: begin
            unique case (status.cmd)
               rmq_pkg::CMD_APPEND:
                  state_in = status.full ? rmq_pkg::S_IDLE : rmq_pkg::S_A_START;
               rmq_pkg::CMD_QUERY: state_in = rmq_pkg::S_Q_CHECK;
               default:            state_in = rmq_pkg::S_IDLE;
            endcase
         end
         rmq_pkg::S_A_START:  state_in = rmq_pkg::S_A_BMIN;
         rmq_pkg::S_A_BMIN:   state_in = rmq_pkg::S_A_POP;
         rmq_pkg::S_A_POP:
            state_in = status.depth_zero ? rmq_pkg::S_A_WRITE : rmq_pkg::S_A_POP_EL;
         rmq_pkg::S_A_POP_EL: state_in = rmq_pkg::S_A_POP_CMP;
         rmq_pkg::S_A_POP_CMP:
            state_in = status.pop_hit ? rmq_pkg::S_A_POP : rmq_pkg::S_A_WRITE;
         rmq_pkg::S_A_WRITE:
            state_in = status.pos_last ? rmq_pkg::S_A_LVL : rmq_pkg::S_IDLE;
         rmq_pkg::S_A_LVL:
            state_in = status.lvl_done ? rmq_pkg::S_IDLE : rmq_pkg::S_A_LVL1;
         rmq_pkg::S_A_LVL1:   state_in = rmq_pkg::S_A_LVL2;
         rmq_pkg::S_A_LVL2:   state_in = rmq_pkg::S_A_LVL;
         rmq_pkg::S_Q_CHECK: begin
            if (status.q_err || status.q_empty) state_in = rmq_pkg::S_Q_OUT;
            else                                state_in = rmq_pkg::S_Q_IB_M;
         end
         rmq_pkg::S_Q_IB_M:   state_in = rmq_pkg::S_Q_IB_E;
         rmq_pkg::S_Q_IB_E: begin
            if (status.right_phase || status.same_block) state_in = rmq_pkg::S_Q_OUT;
            else if (status.has_mid)                     state_in = rmq_pkg::S_Q_MID0;
            else if (status.has_right)                   state_in = rmq_pkg::S_Q_RIGHT;
            else                                         state_in = rmq_pkg::S_Q_OUT;
         end
         rmq_pkg::S_Q_MID0:   state_in = rmq_pkg::S_Q_MID1;
         rmq_pkg::S_Q_MID1:   state_in = rmq_pkg::S_Q_MID2;
         rmq_pkg::S_Q_MID2:
            state_in = status.has_right ? rmq_pkg::S_Q_RIGHT : rmq_pkg::S_Q_OUT;
         rmq_pkg::S_Q_RIGHT:  state_in = rmq_pkg::S_Q_IB_M;
         rmq_pkg::S_Q_OUT: begin
            if (status.rsp_free) state_in = rmq_pkg::S_IDLE;
         end
         default: state_in = rmq_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      op         = rmq_pkg::OP_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         rmq_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) op = rmq_pkg::OP_LOAD;
         end
         rmq_pkg::S_DISPATCH: begin
            if (status.cmd == rmq_pkg::CMD_CLEAR) op = rmq_pkg::OP_CLEAR;
         end
         rmq_pkg::S_A_START:   op = rmq_pkg::OP_A_START;
         rmq_pkg::S_A_BMIN:    op = rmq_pkg::OP_A_BMIN;
         rmq_pkg::S_A_POP:     op = status.depth_zero ? rmq_pkg::OP_NONE : rmq_pkg::OP_POP_RD;
         rmq_pkg::S_A_POP_EL:  op = rmq_pkg::OP_POP_EL;
         rmq_pkg::S_A_POP_CMP: op = rmq_pkg::OP_POP_CMP;
         rmq_pkg::S_A_WRITE:   op = rmq_pkg::OP_A_WRITE;
         rmq_pkg::S_A_LVL:     op = status.lvl_done ? rmq_pkg::OP_NONE : rmq_pkg::OP_LVL_RD0;
         rmq_pkg::S_A_LVL1:    op = rmq_pkg::OP_LVL_RD1;
         rmq_pkg::S_A_LVL2:    op = rmq_pkg::OP_LVL_WR;
         rmq_pkg::S_Q_CHECK: begin
            if (status.q_err)        op = rmq_pkg::OP_Q_ERR;
            else if (status.q_empty) op = rmq_pkg::OP_Q_EMPTY;
            else                     op = rmq_pkg::OP_Q_LEFT;
         end
         rmq_pkg::S_Q_IB_M:    op = rmq_pkg::OP_IB_MASK;
         rmq_pkg::S_Q_IB_E:    op = rmq_pkg::OP_IB_ELEM;
         rmq_pkg::S_Q_MID0:    op = rmq_pkg::OP_MID0;
         rmq_pkg::S_Q_MID1:    op = rmq_pkg::OP_MID1;
         rmq_pkg::S_Q_MID2:    op = rmq_pkg::OP_MID2;
         rmq_pkg::S_Q_RIGHT:   op = rmq_pkg::OP_Q_RIGHT;
         rmq_pkg::S_Q_OUT:     op = status.rsp_free ? rmq_pkg::OP_Q_OUT : rmq_pkg::OP_NONE;
         default:              op = rmq_pkg::OP_NONE;
      endcase
   end

endmodule

/* rtl/core/rmq_datapath.sv */
`timescale 1ns / 1ps

module rmq_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rmq_pkg::dp_op_type                   op,
   input  logic [rmq_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  logic [1:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [rmq_pkg::VALUE_WIDTH-1:0]      rsp_tdata,
   output logic                                 rsp_tuser,
   output rmq_pkg::status_type                  status
);

   localparam int VW = rmq_pkg::VALUE_WIDTH;
   localparam int AW = rmq_pkg::ADDR_W;
   localparam int CW = rmq_pkg::COUNT_W;
   localparam int PW = rmq_pkg::POS_W;
   localparam int BW = rmq_pkg::BLK_W;
   localparam int LW = rmq_pkg::LVL_W;
   localparam int DW = rmq_pkg::DEPTH_W;
   localparam int MW = rmq_pkg::BLOCK_SIZE;
   localparam int TW = $clog2(rmq_pkg::BMT_DEPTH);

   rmq_pkg::command_type cmd_ff, cmd_in;
   logic [VW-1:0] value_ff, value_in;
   logic [CW-1:0] start_ff, start_in, end_ff, end_in, count_ff, count_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [PW-1:0] top_ff, top_in, pos_ff, pos_in, lo_ff, lo_in;
   logic [BW-1:0] blk_ff, blk_in, ibblk_ff, ibblk_in;
   logic [MW-1:0] mask_ff, mask_in;
   logic [VW-1:0] bmin_ff, bmin_in, tmp_ff, tmp_in, best_ff, best_in;
   logic [LW-1:0] lvl_ff, lvl_in, kval_ff, kval_in;
   logic          err_ff, err_in, right_ff, right_in;
   logic [AW-1:0] hiaddr_ff, hiaddr_in;
   logic          rsp_valid_ff, rsp_valid_in, rsp_err_ff, rsp_err_in;
   logic [VW-1:0] rsp_data_ff, rsp_data_in;

   logic [VW-1:0] elem_rdata, bmt_rdata;
   logic [MW-1:0] mask_rdata;
   logic [PW-1:0] stack_rdata;
   logic [AW-1:0] elem_raddr, mask_raddr;
   logic [PW-1:0] stack_raddr;
   logic [TW-1:0] bmt_raddr, bmt_waddr;
   logic [VW-1:0] bmt_wdata;
   logic          row_we, bmt_we;

   logic [DW-1:0] sb, tb, span, blk_plus, lvl_span;
   logic [PW-1:0] sp, tp, lvl_i, lvl_j;
   logic [LW-1:0] kcur;
   logic [MW-1:0] masked;
   logic          lvl_done;

   assign sb       = start_ff[CW-1:PW];
   assign tb       = end_ff[CW-1:PW];
   assign sp       = start_ff[PW-1:0];
   assign tp       = end_ff[PW-1:0];
   assign span     = tb - sb - DW'(1);
   assign kcur     = rmq_pkg::floor_log2(span);
   assign blk_plus = {1'b0, blk_ff} + DW'(1);
   assign lvl_span = DW'(1) << lvl_ff;
   assign lvl_i    = PW'(blk_plus - lvl_span);
   assign lvl_j    = lvl_i + (PW'(1) << (lvl_ff - LW'(1)));
   assign lvl_done = (lvl_ff == LW'(rmq_pkg::NUM_LEVELS)) || (blk_plus < lvl_span);
   assign masked   = mask_rdata & ~((MW'(1) << lo_ff) - MW'(1));

   always_comb begin
      elem_raddr  = {blk_ff, top_ff};
      mask_raddr  = {blk_ff, stack_rdata};
      stack_raddr = PW'(depth_ff - DW'(1));
      bmt_raddr   = {LW'(0), count_ff[AW-1:PW]};
      case (op)
         rmq_pkg::OP_POP_EL: begin
            elem_raddr = {blk_ff, stack_rdata};
            mask_raddr = {blk_ff, stack_rdata};
         end
         rmq_pkg::OP_Q_LEFT:
            mask_raddr = (sb == tb) ? {sb[BW-1:0], tp - PW'(1)} : {sb[BW-1:0], {PW{1'b1}}};
         rmq_pkg::OP_Q_RIGHT: mask_raddr = {tb[BW-1:0], tp - PW'(1)};
         rmq_pkg::OP_IB_MASK:
            elem_raddr = (masked == '0) ? hiaddr_ff
                                        : {ibblk_ff, rmq_pkg::lowest_bit(masked)};
         rmq_pkg::OP_LVL_RD0: bmt_raddr = {lvl_ff - LW'(1), lvl_i};
         rmq_pkg::OP_LVL_RD1: bmt_raddr = {lvl_ff - LW'(1), lvl_j};
         rmq_pkg::OP_MID0:    bmt_raddr = {kcur, PW'(sb + DW'(1))};
         rmq_pkg::OP_MID1:    bmt_raddr = {kval_ff, PW'(tb - (DW'(1) << kval_ff))};
         default: ;
      endcase
   end

   assign row_we = (op == rmq_pkg::OP_A_WRITE);
   assign bmt_we = row_we || (op == rmq_pkg::OP_LVL_WR);

   always_comb begin
      if (row_we) begin
         bmt_waddr = {LW'(0), blk_ff};
         bmt_wdata = (pos_ff == '0 || value_ff < bmin_ff) ? value_ff : bmin_ff;
      end else begin
         bmt_waddr = {lvl_ff, lvl_i};
         bmt_wdata = (tmp_ff < bmt_rdata) ? tmp_ff : bmt_rdata;
      end
   end

   rmq_ram #(.WIDTH(VW), .DEPTH(rmq_pkg::MAX_ELEMENTS)) u_elem (
      .clock(clock), .wr_en(row_we), .wr_addr(count_ff[AW-1:0]), .wr_data(value_ff),
      .rd_addr(elem_raddr), .rd_data(elem_rdata));

   rmq_ram #(.WIDTH(MW), .DEPTH(rmq_pkg::MAX_ELEMENTS)) u_mask (
      .clock(clock), .wr_en(row_we), .wr_addr(count_ff[AW-1:0]), .wr_data(mask_ff),
      .rd_addr(mask_raddr), .rd_data(mask_rdata));

   rmq_ram #(.WIDTH(PW), .DEPTH(rmq_pkg::BLOCK_SIZE)) u_stack (
      .clock(clock), .wr_en(row_we), .wr_addr(depth_ff[PW-1:0]), .wr_data(pos_ff),
      .rd_addr(stack_raddr), .rd_data(stack_rdata));

   rmq_ram #(.WIDTH(VW), .DEPTH(rmq_pkg::BMT_DEPTH)) u_bmt (
      .clock(clock), .wr_en(bmt_we), .wr_addr(bmt_waddr), .wr_data(bmt_wdata),
      .rd_addr(bmt_raddr), .rd_data(bmt_rdata));

   always_comb begin
      cmd_in = cmd_ff;  value_in = value_ff;  start_in = start_ff;  end_in = end_ff;
      count_in = count_ff;  depth_in = depth_ff;  top_in = top_ff;  pos_in = pos_ff;
      lo_in = lo_ff;  blk_in = blk_ff;  ibblk_in = ibblk_ff;  mask_in = mask_ff;
      bmin_in = bmin_ff;  tmp_in = tmp_ff;  best_in = best_ff;  lvl_in = lvl_ff;
      kval_in = kval_ff;  err_in = err_ff;  right_in = right_ff;  hiaddr_in = hiaddr_ff;
      rsp_data_in = rsp_data_ff;  rsp_err_in = rsp_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (op)
         rmq_pkg::OP_LOAD: begin
            cmd_in   = rmq_pkg::command_type'(req_tuser);
            value_in = req_tdata[VW-1:0];
            start_in = req_tdata[VW+CW-1:VW];
            end_in   = req_tdata[VW+2*CW-1:VW+CW];
         end
         rmq_pkg::OP_CLEAR: begin
            count_in = '0;
            depth_in = '0;
         end
         rmq_pkg::OP_A_START: begin
            pos_in  = count_ff[PW-1:0];
            blk_in  = count_ff[AW-1:PW];
            mask_in = '0;
            if (count_ff[PW-1:0] == '0) depth_in = '0;
         end
         rmq_pkg::OP_A_BMIN: bmin_in = bmt_rdata;
         rmq_pkg::OP_POP_EL: top_in = stack_rdata;
         rmq_pkg::OP_POP_CMP: begin
            if (elem_rdata >= value_ff) depth_in = depth_ff - DW'(1);
            else mask_in = mask_rdata | (MW'(1) << top_ff);
         end
         rmq_pkg::OP_A_WRITE: begin
            depth_in = depth_ff + DW'(1);
            count_in = count_ff + CW'(1);
            lvl_in   = LW'(1);
         end
         rmq_pkg::OP_LVL_RD1: tmp_in = bmt_rdata;
         rmq_pkg::OP_LVL_WR:  lvl_in = lvl_ff + LW'(1);
         rmq_pkg::OP_Q_ERR: begin
            best_in = '1;
            err_in  = 1'b1;
         end
         rmq_pkg::OP_Q_EMPTY: begin
            best_in = '1;
            err_in  = 1'b0;
         end
         rmq_pkg::OP_Q_LEFT: begin
            best_in   = '1;
            err_in    = 1'b0;
            right_in  = 1'b0;
            lo_in     = sp;
            ibblk_in  = sb[BW-1:0];
            hiaddr_in = (sb == tb) ? {sb[BW-1:0], tp - PW'(1)} : {sb[BW-1:0], {PW{1'b1}}};
         end
         rmq_pkg::OP_Q_RIGHT: begin
            right_in  = 1'b1;
            lo_in     = '0;
            ibblk_in  = tb[BW-1:0];
            hiaddr_in = {tb[BW-1:0], tp - PW'(1)};
         end
         rmq_pkg::OP_IB_ELEM: if (elem_rdata < best_ff) best_in = elem_rdata;
         rmq_pkg::OP_MID0: kval_in = kcur;
         rmq_pkg::OP_MID1, rmq_pkg::OP_MID2: if (bmt_rdata < best_ff) best_in = bmt_rdata;
         rmq_pkg::OP_Q_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = best_ff;
            rsp_err_in   = err_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;  value_ff <= value_in;  start_ff <= start_in;  end_ff <= end_in;
      top_ff <= top_in;  pos_ff <= pos_in;  lo_ff <= lo_in;  blk_ff <= blk_in;
      ibblk_ff <= ibblk_in;  mask_ff <= mask_in;  bmin_ff <= bmin_in;  tmp_ff <= tmp_in;
      best_ff <= best_in;  lvl_ff <= lvl_in;  kval_ff <= kval_in;  err_ff <= err_in;
      right_ff <= right_in;  hiaddr_ff <= hiaddr_in;
      rsp_data_ff <= rsp_data_in;  rsp_err_ff <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

   always_comb begin
      status.cmd         = cmd_ff;
      status.full        = (count_ff >= CW'(rmq_pkg::MAX_ELEMENTS));
      status.depth_zero  = (depth_ff == '0);
      status.pop_hit     = (elem_rdata >= value_ff);
      status.pos_last    = (pos_ff == {PW{1'b1}});
      status.lvl_done    = lvl_done;
      status.q_err       = (start_ff > end_ff) || (end_ff > count_ff);
      status.q_empty     = (start_ff == end_ff);
      status.same_block  = (sb == tb);
      status.has_mid     = ((sb + DW'(1)) < tb);
      status.has_right   = (tp != '0);
      status.right_phase = right_ff;
      status.rsp_free    = !rsp_valid_ff || rsp_tready;
   end

endmodule

/* rtl/core/range_minimum_query.sv */
`timescale 1ns / 1ps
// Appends read the block minimum, pop stack entries whose values are not below the new one,
// write the element and, when it completes a block, fill the sparse-table levels; clear and
// ignored commands return to idle. A query on an error or empty range goes straight to its
// response; others first scan the left block, the whole-block run and the right block.
// Requests are taken one at a time: req_tready is high only while the controller is idle.
// Reset (synchronous, active high) empties the sequence; RAM contents are not cleared.

module range_minimum_query (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata from bit 0: value[31:0], range_start[44:32], range_end[57:45], zero pad.
   input  logic [rmq_pkg::REQ_DATA_W-1:0]      req_tdata,
   // tuser: command (0 clear, 1 append, 2 query).
   input  logic [1:0]                          req_tuser,
   // Response channel, one beat per query.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: minimum[31:0].
   output logic [rmq_pkg::VALUE_WIDTH-1:0]     rsp_tdata,
   // tuser: range_error.
   output logic                                rsp_tuser
);

   // The controller sequences appends (stack pops, block minimum, table levels)
   // and queries (left block, whole-block run, right block) by issuing at most one
   // datapath operation per cycle, reacting to the datapath status.
   rmq_pkg::status_type status;
   rmq_pkg::dp_op_type  op;

   rmq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .op         (op)
   );

   rmq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .status     (status)
   );

   // An accepted beat is always latched by the datapath.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> (op == rmq_pkg::OP_LOAD))
      else $error("accepted beat not loaded");

   // A range error always reports an all-ones minimum.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '1))
      else $error("range error with a real minimum");

   // A clear is applied in the dispatch state; afterwards the store is no longer full.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == rmq_pkg::CMD_CLEAR) |=> ##1 !status.full)
      else $error("clear did not empty the store");

   // A response is only loaded when the output register is free.
   assert property (@(posedge clock) disable iff (reset)
      (op == rmq_pkg::OP_Q_OUT) |-> (!rsp_tvalid || rsp_tready))
      else $error("response overwritten");

endmodule
